/* rtl/assert_macros.svh */
// assertion helpers, clocked on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/gds_pkg.sv */
package gds_pkg;

  localparam int DEF_GRID_W = 64;
  localparam int DEF_GRID_H = 64;

  // width of the coordinate fields on the ports
  localparam int IN_W = 6;
  localparam int MODE_W = 2;
  localparam int KIND_W = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACKTRACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // up is (0,+1), down (0,-1), left (-1,0), right (+1,0)
  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_e;

  function automatic dir_e dir_sel(logic order, logic [1:0] step);
    dir_e dir;
    dir = DIR_UP;
    if (!order) begin
      case (step)
        2'd0: dir = DIR_UP;
        2'd1: dir = DIR_DOWN;
        2'd2: dir = DIR_LEFT;
        default: dir = DIR_RIGHT;
      endcase
    end else begin
      case (step)
        2'd0: dir = DIR_LEFT;
        2'd1: dir = DIR_DOWN;
        2'd2: dir = DIR_RIGHT;
        default: dir = DIR_UP;
      endcase
    end
    return dir;
  endfunction

endpackage

/* rtl/grid_dfs_stepper.sv */
// Depth-first walker over a GRID_W x GRID_H grid with 4-neighbour moves. An item is taken when
// start is high and busy low; busy stays high until the item is finished, and a walk step's
// report appears for one cycle on out_valid_o with no way for the receiver to stall it. The
// cell flags and path stack sit in two one-port-read memories with registered read data.
// After reset a clearing pass zeroes the cell memory (busy high); configuration writes are
// taken at any time. A step probes the neighbours in turn, one per cycle through the cell
// memory read port; it reports an advance at the first free one, else a backtrack, or a
// restart if the stack empties. A restart sweeps the visited flags one cell per cycle.
`include "assert_macros.svh"

module grid_dfs_stepper #(
  parameter int GRID_W = gds_pkg::DEF_GRID_W,
  parameter int GRID_H = gds_pkg::DEF_GRID_H
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [gds_pkg::MODE_W-1:0] mode_i,
  input  logic [gds_pkg::IN_W-1:0]   x_i,
  input  logic [gds_pkg::IN_W-1:0]   y_i,
  input  logic                       passable_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_direction_order_i,
  output logic                       out_valid_o,
  output logic [gds_pkg::IN_W-1:0]   out_x_o,
  output logic [gds_pkg::IN_W-1:0]   out_y_o,
  output logic [gds_pkg::KIND_W-1:0] step_kind_o
);

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW = $clog2(CELLS);
  localparam int CW = AW + 1;
  localparam int XW = ($clog2(GRID_W) > gds_pkg::IN_W) ? $clog2(GRID_W) : gds_pkg::IN_W;
  localparam int YW = ($clog2(GRID_H) > gds_pkg::IN_W) ? $clog2(GRID_H) : gds_pkg::IN_W;
  localparam logic [CW-1:0] CELLS_C = CW'(CELLS);
  localparam logic [AW-1:0] LAST_C = AW'(CELLS - 1);
  localparam logic [XW:0] GW_C = (XW + 1)'(GRID_W);
  localparam logic [YW:0] GH_C = (YW + 1)'(GRID_H);

  // cell flag bits
  localparam int F_PASS = 1;
  localparam int F_VIS = 0;

  typedef struct packed {
    logic [YW-1:0] y;
    logic [XW-1:0] x;
  } coord_t;

  typedef struct packed {
    logic          ok;
    logic [AW-1:0] idx;
    coord_t        c;
  } probe_t;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_LD    = 9'b000000100,
    S_INIT  = 9'b000001000,
    S_TOP   = 9'b000010000,
    S_CHECK = 9'b000100000,
    S_BACK  = 9'b001000000,
    S_WIPE  = 9'b010000000,
    S_WLAST = 9'b100000000
  } state_e;

  // one extra bit: a move below zero wraps to all ones and fails the bound test
  function automatic probe_t locate(logic [XW:0] nx, logic [YW:0] ny);
    probe_t p;
    p.ok = (nx < GW_C) && (ny < GH_C);
    p.idx = AW'(32'(ny) * 32'(GRID_W) + 32'(nx));
    p.c.x = nx[XW-1:0];
    p.c.y = ny[YW-1:0];
    return p;
  endfunction

  function automatic probe_t probe(coord_t c, gds_pkg::dir_e dir);
    logic [XW:0] nx;
    logic [YW:0] ny;
    nx = {1'b0, c.x};
    ny = {1'b0, c.y};
    case (dir)
      gds_pkg::DIR_UP:    ny = ny + 1'b1;
      gds_pkg::DIR_DOWN:  ny = ny - 1'b1;
      gds_pkg::DIR_LEFT:  nx = nx - 1'b1;
      default:            nx = nx + 1'b1;
    endcase
    return locate(nx, ny);
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] count_q, count_d;
  coord_t        origin_q, origin_d;
  coord_t        top_q, top_d;
  logic [1:0]    dir_q, dir_d;
  logic          restart_q, restart_d;
  logic          order_q, order_d;
  logic          wipe_pend_q, wipe_pend_d;
  logic [AW-1:0] wipe_wa_q, wipe_wa_d;
  logic          ld_ok_q, ld_ok_d;
  logic          ld_pass_q, ld_pass_d;
  logic [AW-1:0] ld_idx_q, ld_idx_d;

  logic                       out_valid_q, out_valid_d;
  logic [gds_pkg::IN_W-1:0]   out_x_q, out_x_d;
  logic [gds_pkg::IN_W-1:0]   out_y_q, out_y_d;
  logic [gds_pkg::KIND_W-1:0] kind_q, kind_d;

  // cell memory: passable and visited flags
  logic [1:0]    cell_mem [CELLS];
  logic [1:0]    cell_rd_q;
  logic [AW-1:0] cell_raddr;
  logic          cell_we;
  logic [AW-1:0] cell_waddr;
  logic [1:0]    cell_wdata;

  // path stack memory
  coord_t        stk_mem [CELLS];
  coord_t        stk_rd_q;
  logic [AW-1:0] stk_raddr;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  coord_t        stk_wdata;

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  coord_t     in_c;
  probe_t     in_loc;
  probe_t     org_loc;
  coord_t     top_src;
  logic [1:0] dir_next;
  probe_t     pr_cur;
  probe_t     pr_next;

  assign in_c    = '{y: YW'(y_i), x: XW'(x_i)};
  assign in_loc  = locate({1'b0, in_c.x}, {1'b0, in_c.y});
  assign org_loc = locate({1'b0, origin_q.x}, {1'b0, origin_q.y});
  // the first probe is issued straight from the stack read data
  assign top_src  = (state_q == S_TOP) ? stk_rd_q : top_q;
  assign dir_next = (state_q == S_TOP) ? 2'd0 : 2'(dir_q + 1'b1);
  assign pr_cur   = probe(top_q, gds_pkg::dir_sel(order_q, dir_q));
  assign pr_next  = probe(top_src, gds_pkg::dir_sel(order_q, dir_next));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    origin_d    = origin_q;
    top_d       = top_q;
    dir_d       = dir_q;
    restart_d   = restart_q;
    order_d     = order_q;
    wipe_pend_d = wipe_pend_q;
    wipe_wa_d   = wipe_wa_q;
    ld_ok_d     = ld_ok_q;
    ld_pass_d   = ld_pass_q;
    ld_idx_d    = ld_idx_q;
    out_valid_d = 1'b0;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    kind_d      = kind_q;

    cell_raddr = in_loc.idx;
    cell_we    = 1'b0;
    cell_waddr = cnt_q;
    cell_wdata = '0;
    stk_raddr  = AW'(count_q - 1'b1);
    stk_we     = 1'b0;
    stk_waddr  = count_q[AW-1:0];
    stk_wdata  = origin_q;

    if (cfg_valid_i) begin
      order_d = cfg_direction_order_i;
    end

    unique case (state_q)
      S_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = cnt_q;
        cell_wdata = '0;
        cnt_d      = AW'(cnt_q + 1'b1);
        if (cnt_q == LAST_C) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (mode_i)
            gds_pkg::MODE_LOAD: begin
              ld_ok_d   = in_loc.ok;
              ld_idx_d  = in_loc.idx;
              ld_pass_d = passable_i;
              state_d   = S_LD;
            end
            gds_pkg::MODE_INIT: begin
              origin_d  = in_c;
              restart_d = 1'b0;
              state_d   = S_INIT;
            end
            gds_pkg::MODE_STEP: begin
              if (count_q == '0) begin
                restart_d = 1'b1;
                cnt_d     = '0;
                state_d   = S_WIPE;
              end else begin
                state_d = S_TOP;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LD: begin
        if (ld_ok_q) begin
          cell_we    = 1'b1;
          cell_waddr = ld_idx_q;
          cell_wdata = {ld_pass_q, cell_rd_q[F_VIS]};
        end
        state_d = S_IDLE;
      end
      S_INIT: begin
        if (org_loc.ok && cell_rd_q[F_PASS]) begin
          cell_we    = 1'b1;
          cell_waddr = org_loc.idx;
          cell_wdata = 2'b11;
        end
        if (count_q < CELLS_C) begin
          stk_we    = 1'b1;
          stk_wdata = origin_q;
          count_d   = CW'(count_q + 1'b1);
        end
        if (restart_q) begin
          out_valid_d = 1'b1;
          out_x_d     = origin_q.x[gds_pkg::IN_W-1:0];
          out_y_d     = origin_q.y[gds_pkg::IN_W-1:0];
          kind_d      = gds_pkg::KIND_RESTART;
        end
        state_d = S_IDLE;
      end
      S_TOP: begin
        top_d      = stk_rd_q;
        dir_d      = 2'd0;
        cell_raddr = pr_next.idx;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cell_raddr = pr_next.idx;
        if (pr_cur.ok && cell_rd_q[F_PASS] && !cell_rd_q[F_VIS]) begin
          cell_we    = 1'b1;
          cell_waddr = pr_cur.idx;
          cell_wdata = 2'b11;
          // a full stack drops the push, the move is still reported
          if (count_q < CELLS_C) begin
            stk_we    = 1'b1;
            stk_wdata = pr_cur.c;
            count_d   = CW'(count_q + 1'b1);
          end
          out_valid_d = 1'b1;
          out_x_d     = pr_cur.c.x[gds_pkg::IN_W-1:0];
          out_y_d     = pr_cur.c.y[gds_pkg::IN_W-1:0];
          kind_d      = gds_pkg::KIND_ADVANCE;
          state_d     = S_IDLE;
        end else if (dir_q == 2'd3) begin
          count_d = CW'(count_q - 1'b1);
          if (count_q > CW'(1)) begin
            stk_raddr = AW'(count_q - 2'd2);
            state_d   = S_BACK;
          end else begin
            restart_d = 1'b1;
            cnt_d     = '0;
            state_d   = S_WIPE;
          end
        end else begin
          dir_d = dir_next;
        end
      end
      S_BACK: begin
        out_valid_d = 1'b1;
        out_x_d     = stk_rd_q.x[gds_pkg::IN_W-1:0];
        out_y_d     = stk_rd_q.y[gds_pkg::IN_W-1:0];
        kind_d      = gds_pkg::KIND_BACKTRACK;
        state_d     = S_IDLE;
      end
      S_WIPE: begin
        // read one cell ahead, write back the cell read last cycle with visited cleared
        cell_raddr = cnt_q;
        if (wipe_pend_q) begin
          cell_we    = 1'b1;
          cell_waddr = wipe_wa_q;
          cell_wdata = {cell_rd_q[F_PASS], 1'b0};
        end
        wipe_pend_d = 1'b1;
        wipe_wa_d   = cnt_q;
        cnt_d       = AW'(cnt_q + 1'b1);
        if (cnt_q == LAST_C) begin
          cnt_d   = '0;
          state_d = S_WLAST;
        end
      end
      S_WLAST: begin
        // only the passable bit of the origin is used, so the same-cell write is harmless
        cell_we     = 1'b1;
        cell_waddr  = wipe_wa_q;
        cell_wdata  = {cell_rd_q[F_PASS], 1'b0};
        wipe_pend_d = 1'b0;
        cell_raddr  = org_loc.idx;
        state_d     = S_INIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      count_q     <= '0;
      origin_q    <= '0;
      dir_q       <= '0;
      restart_q   <= 1'b0;
      order_q     <= 1'b0;
      wipe_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      origin_q    <= origin_d;
      dir_q       <= dir_d;
      restart_q   <= restart_d;
      order_q     <= order_d;
      wipe_pend_q <= wipe_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    wipe_wa_q <= wipe_wa_d;
    ld_ok_q   <= ld_ok_d;
    ld_pass_q <= ld_pass_d;
    ld_idx_q  <= ld_idx_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
    kind_q    <= kind_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign step_kind_o = kind_q;

  `ASSERT_NEXT(a_report_single, out_valid_q, !out_valid_q, "two reports in a row")
  `ASSERT_ALWAYS(a_count_bound, count_q <= CELLS_C, "stack count beyond depth")
  `ASSERT_IMPLIES(a_probe_has_top, state_q == S_CHECK, count_q != '0, "probe with empty stack")
  `ASSERT_IMPLIES(a_idle_no_write, !busy, !cell_we && !stk_we, "memory write while idle")

endmodule

/* tb/grid_dfs_stepper_tb.sv */
module grid_dfs_stepper_tb;

  localparam int MODE_W = gds_pkg::MODE_W;
  localparam int IN_W = gds_pkg::IN_W;
  localparam int KIND_W = gds_pkg::KIND_W;
  localparam int GRID_W = gds_pkg::DEF_GRID_W;
  localparam int GRID_H = gds_pkg::DEF_GRID_H;
  localparam int CELLS = GRID_W * GRID_H;
  localparam int RAND_ITEMS = 900;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [IN_W-1:0]   cx;
    logic [IN_W-1:0]   cy;
    logic [KIND_W-1:0] kind;
  } walk_rpt_t;

  typedef struct packed {
    logic              is_cfg;
    logic [MODE_W-1:0] md;
    logic [IN_W-1:0]   cx;
    logic [IN_W-1:0]   cy;
    logic              pv;
    logic              typed;
    walk_rpt_t         rpt;
  } plan_row_t;

  localparam walk_rpt_t NO_RPT = '0;
  localparam walk_rpt_t ORIGIN_RESTART = '{6'd0, 6'd0, gds_pkg::KIND_RESTART};

  localparam int PLAN_LEN = 25;
  // cfg rows carry the register value in pv
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd0,  1'b0, 1'b1, ORIGIN_RESTART},
    '{1'b0, gds_pkg::MODE_STEP, 6'd63, 6'd63, 1'b1, 1'b1, ORIGIN_RESTART},
    '{1'b0, gds_pkg::MODE_LOAD, 6'd0,  6'd0,  1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_LOAD, 6'd0,  6'd1,  1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_LOAD, 6'd63, 6'd63, 1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_LOAD, 6'd62, 6'd63, 1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_LOAD, 6'd63, 6'd62, 1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_INIT, 6'd63, 6'd63, 1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd63, 6'd0,  1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd63, 1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd21, 6'd42, 1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd42, 6'd21, 1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT},
    '{1'b0, MODE_NONE,          6'd63, 6'd63, 1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_LOAD, 6'd63, 6'd63, 1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_INIT, 6'd0,  6'd0,  1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_INIT, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT},
    '{1'b1, gds_pkg::MODE_LOAD, 6'd0,  6'd0,  1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd63, 6'd63, 1'b1, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT},
    '{1'b1, gds_pkg::MODE_LOAD, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT},
    '{1'b0, gds_pkg::MODE_STEP, 6'd0,  6'd0,  1'b0, 1'b0, NO_RPT}
  };

  localparam gds_pkg::dir_e PROBE_SEQ [2][4] = '{
    '{gds_pkg::DIR_UP, gds_pkg::DIR_DOWN, gds_pkg::DIR_LEFT, gds_pkg::DIR_RIGHT},
    '{gds_pkg::DIR_LEFT, gds_pkg::DIR_DOWN, gds_pkg::DIR_RIGHT, gds_pkg::DIR_UP}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [MODE_W-1:0] mode_i = gds_pkg::MODE_LOAD;
  logic [IN_W-1:0]   x_i = '0;
  logic [IN_W-1:0]   y_i = '0;
  logic              passable_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_direction_order_i = 1'b0;
  logic              out_valid_o;
  logic [IN_W-1:0]   out_x_o;
  logic [IN_W-1:0]   out_y_o;
  logic [KIND_W-1:0] step_kind_o;

  // walker state as the block should hold it
  bit        pass_map [CELLS];
  bit        seen_map [CELLS];
  int        path_x [CELLS];
  int        path_y [CELLS];
  int        path_depth = 0;
  int        org_x = 0;
  int        org_y = 0;
  logic      dir_order = 1'b0;
  walk_rpt_t expected_walk_q [$];
  int        mismatches = 0;
  int        sent_items = 0;

  grid_dfs_stepper dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .mode_i                (mode_i),
    .x_i                   (x_i),
    .y_i                   (y_i),
    .passable_i            (passable_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_direction_order_i (cfg_direction_order_i),
    .out_valid_o           (out_valid_o),
    .out_x_o               (out_x_o),
    .out_y_o               (out_y_o),
    .step_kind_o           (step_kind_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int offset_x(gds_pkg::dir_e d);
    case (d)
      gds_pkg::DIR_LEFT:  return -1;
      gds_pkg::DIR_RIGHT: return 1;
      default:            return 0;
    endcase
  endfunction

  function automatic int offset_y(gds_pkg::dir_e d);
    case (d)
      gds_pkg::DIR_UP:   return 1;
      gds_pkg::DIR_DOWN: return -1;
      default:           return 0;
    endcase
  endfunction

  function automatic bit on_grid(int cx, int cy);
    return cx >= 0 && cy >= 0 && cx < GRID_W && cy < GRID_H;
  endfunction

  function automatic int cell_of(int cx, int cy);
    return cy * GRID_W + cx;
  endfunction

  function automatic logic [IN_W-1:0] rnd_coord();
    return IN_W'($urandom_range(0, 63));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // pushes past a full stack are dropped
  task automatic push_path(int cx, int cy);
    if (path_depth < CELLS) begin
      path_x[path_depth] = cx;
      path_y[path_depth] = cy;
      path_depth++;
    end
  endtask

  task automatic enter_at(int cx, int cy);
    org_x = cx;
    org_y = cy;
    push_path(cx, cy);
    if (on_grid(cx, cy) && pass_map[cell_of(cx, cy)]) seen_map[cell_of(cx, cy)] = 1'b1;
  endtask

  task automatic walk_model(input logic [MODE_W-1:0] md, input logic [IN_W-1:0] cx,
                            input logic [IN_W-1:0] cy, input logic pv,
                            output bit got, output walk_rpt_t rpt);
    int tx;
    int ty;
    int nx;
    int ny;
    bit found;
    got = 1'b0;
    rpt = '0;
    found = 1'b0;
    case (md)
      gds_pkg::MODE_LOAD: if (on_grid(cx, cy)) pass_map[cell_of(cx, cy)] = pv;
      gds_pkg::MODE_INIT: enter_at(cx, cy);
      gds_pkg::MODE_STEP: begin
        got = 1'b1;
        if (path_depth > 0) begin
          tx = path_x[path_depth-1];
          ty = path_y[path_depth-1];
          for (int k = 0; k < 4 && !found; k++) begin
            nx = tx + offset_x(PROBE_SEQ[dir_order][k]);
            ny = ty + offset_y(PROBE_SEQ[dir_order][k]);
            if (on_grid(nx, ny) && pass_map[cell_of(nx, ny)] && !seen_map[cell_of(nx, ny)]) begin
              seen_map[cell_of(nx, ny)] = 1'b1;
              push_path(nx, ny);
              rpt = '{IN_W'(nx), IN_W'(ny), gds_pkg::KIND_ADVANCE};
              found = 1'b1;
            end
          end
          if (!found) begin
            path_depth--;
            if (path_depth > 0) begin
              rpt = '{IN_W'(path_x[path_depth-1]), IN_W'(path_y[path_depth-1]),
                      gds_pkg::KIND_BACKTRACK};
              found = 1'b1;
            end
          end
        end
        // empty stack: wipe visited flags and start over at the origin
        if (!found) begin
          for (int i = 0; i < CELLS; i++) seen_map[i] = 1'b0;
          enter_at(org_x, org_y);
          rpt = '{IN_W'(org_x), IN_W'(org_y), gds_pkg::KIND_RESTART};
        end
      end
      default: ;
    endcase
  endtask

  task automatic issue(input logic [MODE_W-1:0] md, input logic [IN_W-1:0] cx,
                       input logic [IN_W-1:0] cy, input logic pv,
                       input bit typed = 1'b0, input walk_rpt_t typed_rpt = '0);
    bit got;
    walk_rpt_t rpt;
    int pct;
    pct = (sent_items < 300) ? 15 : (sent_items < 600) ? 45 : 0;
    if ($urandom_range(0, 99) < pct) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk_i);
        start = 1'b0;
      end
    end
    @(negedge clk_i);
    start = 1'b1;
    mode_i = md;
    x_i = cx;
    y_i = cy;
    passable_i = pv;
    do @(posedge clk_i); while (busy);
    walk_model(md, cx, cy, pv, got, rpt);
    if (got) expected_walk_q.push_back(typed ? typed_rpt : rpt);
    if (md != MODE_NONE) sent_items++;
  endtask

  // hold off until every report is in and the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_walk_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_order(input logic v);
    settle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_direction_order_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    dir_order = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic noise_item(input bit allow_walk);
    case ($urandom_range(0, allow_walk ? 3 : 1))
      0: issue(MODE_NONE, rnd_coord(), rnd_coord(), rnd_bit());
      1: issue(gds_pkg::MODE_LOAD, rnd_coord(), rnd_coord(), rnd_bit());
      2: issue(gds_pkg::MODE_INIT, rnd_coord(), rnd_coord(), rnd_bit());
      default: issue(gds_pkg::MODE_STEP, rnd_coord(), rnd_coord(), rnd_bit());
    endcase
  endtask

  function automatic int pick_base();
    int r;
    r = int'($urandom_range(0, 3));
    if (r == 0) return 0;
    if (r == 1) return GRID_W - 4;
    return int'($urandom_range(0, GRID_W - 4));
  endfunction

  always @(posedge clk_i) begin
    walk_rpt_t want;
    if (rst_ni && out_valid_o) begin
      if (expected_walk_q.size() == 0) begin
        $display("%0t: walk report with none pending: x=%0d y=%0d kind=%0d",
                 $time, out_x_o, out_y_o, step_kind_o);
        mismatches++;
      end else begin
        want = expected_walk_q.pop_front();
        if (out_x_o !== want.cx) begin
          $display("%0t: out_x expected %0d got %0d", $time, want.cx, out_x_o);
          mismatches++;
        end
        if (out_y_o !== want.cy) begin
          $display("%0t: out_y expected %0d got %0d", $time, want.cy, out_y_o);
          mismatches++;
        end
        if (step_kind_o !== want.kind) begin
          $display("%0t: step_kind expected %0d got %0d", $time, want.kind, step_kind_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int bx;
    int by;
    int ox;
    int oy;
    int rand_start;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) write_order(PLAN[i].pv);
      else issue(PLAN[i].md, PLAN[i].cx, PLAN[i].cy, PLAN[i].pv, PLAN[i].typed, PLAN[i].rpt);
    end

    // episodes: lay out a small patch, start in it, then walk
    rand_start = sent_items;
    while (sent_items - rand_start < RAND_ITEMS) begin
      write_order(rnd_bit());
      repeat ($urandom_range(0, 3)) noise_item(1'b1);
      bx = pick_base();
      by = pick_base();
      ox = int'($urandom_range(0, 3));
      oy = int'($urandom_range(0, 3));
      for (int dy = 0; dy < 4; dy++) begin
        for (int dx = 0; dx < 4; dx++) begin
          issue(gds_pkg::MODE_LOAD, IN_W'(bx + dx), IN_W'(by + dy),
                (dx == ox && dy == oy) ? 1'b1 : ($urandom_range(0, 9) < 8));
        end
      end
      issue(gds_pkg::MODE_INIT, IN_W'(bx + ox), IN_W'(by + oy), rnd_bit());
      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(0, 9) == 0) noise_item(1'b0);
        else issue(gds_pkg::MODE_STEP, rnd_coord(), rnd_coord(), rnd_bit());
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
